### hdl/rendezvous_message_matcher_unit_assert.svh
`ifndef RENDEZVOUS_MESSAGE_MATCHER_UNIT_ASSERT_SVH
`define RENDEZVOUS_MESSAGE_MATCHER_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define RMM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmm check failed");
// implication checked in the cycle after the antecedent
`define RMM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rmm check failed");
`endif

### hdl/rmm_pkg.sv
package rmm_pkg;
	typedef enum logic [2:0] {
		REQ_REGISTER = 3'd0,
		REQ_SEND     = 3'd1,
		REQ_RECEIVE  = 3'd2,
		REQ_COLLECT  = 3'd3,
		REQ_QUERY    = 3'd4
	} req_t;

	localparam logic [1:0] WAIT_IDLE = 2'd0;
	localparam logic [1:0] WAIT_SEND = 2'd1;
	localparam logic [1:0] WAIT_RECV = 2'd2;
	localparam logic [15:0] CNT_MAX = 16'hffff;
	localparam logic [3:0] PEND_MAX = 4'hf;

	typedef struct packed {
		logic       reg_v;
		logic [1:0] wait_kind;
		logic [7:0] partner;
		logic [3:0] pend;
		logic [15:0] sent;
		logic [15:0] recv;
	} ep_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_ME,
		ST_RD_PEER,
		ST_WR,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_EMIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic clr_wr;
		logic load_req;
		logic rd_me;
		logic rd_peer;
		logic do_pair;
		logic scan_rd;
		logic scan_chk;
		logic emit;
		logic out_load;
		logic out_done;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic is_pair;
		logic is_scan;
		logic is_collect;
		logic scan_hit;
		logic scan_end;
		logic emit_end;
		logic out_busy;
	} sts_t;
endpackage

### hdl/rendezvous_message_matcher_unit.sv
// Rendezvous matcher for (node, pid) endpoints. After reset the endpoint table is
// cleared one entry a cycle, all NODES*PIDS entries, before the first request is taken.
// Send and receive read the requester entry, then the partner entry, then write back
// through the single write port of the table, the partner entry (on a match) in the
// cycle after the requester; register and other one-result requests skip the partner
// read. Collect and query scan the PIDS entries of one node with a read step and a
// check step per entry, plus an emit step and a re-read of the entry per returned
// completion; results leave through an output register, and a result waiting there
// stalls the scan and holds off the next request.
module rendezvous_message_matcher_unit
	import rmm_pkg::*;
#(
	parameter int NODES = 16,
	parameter int PIDS = 16,
	parameter int MAX_COLLECT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [3:0]  node,
	input  logic [3:0]  pid,
	input  logic [3:0]  partner_node,
	input  logic [3:0]  partner_pid,
	input  logic [4:0]  max_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        matched,
	output logic        valid_res,
	output logic [3:0]  ready_pid,
	output logic [15:0] sent_total,
	output logic [15:0] received_total,
	output logic        busy_res,
	output logic        overflow,
	output logic        last
);
	cmd_t cmd;
	sts_t sts;

	rmm_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .sts, .cmd
	);

	rmm_dpath #(.NODES(NODES), .PIDS(PIDS), .MAX_COLLECT(MAX_COLLECT)) u_dpath (
		.clk, .arst_n, .cmd, .sts, .req_type, .node, .pid, .partner_node,
		.partner_pid, .max_count, .out_valid, .out_ready, .matched, .valid_res,
		.ready_pid, .sent_total, .received_total, .busy_res, .overflow, .last
	);
endmodule

### hdl/rmm_ctrl.sv
module rmm_ctrl
	import rmm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = !sts.out_busy;
				if (in_valid && !sts.out_busy) begin
					cmd.load_req = 1'b1;
					state_d = ST_RD_ME;
				end
			end
			ST_RD_ME: begin
				cmd.rd_me = 1'b1;
				if (sts.is_pair) state_d = ST_RD_PEER;
				else if (sts.is_scan) state_d = ST_SCAN_RD;
				else state_d = ST_WR;
			end
			ST_RD_PEER: begin
				cmd.rd_peer = 1'b1;
				state_d = ST_WR;
			end
			ST_WR: begin
				cmd.do_pair = 1'b1;
				state_d = ST_OUT;
			end
			ST_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				cmd.scan_rd = 1'b1;
				cmd.scan_chk = 1'b1;
				if (sts.scan_hit && sts.is_collect) state_d = ST_EMIT;
				else if (sts.scan_end) state_d = ST_OUT;
				else state_d = ST_SCAN_RD;
			end
			ST_EMIT: begin
				cmd.scan_rd = 1'b1;
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					if (sts.emit_end) state_d = ST_OUT;
					else state_d = ST_SCAN_RD;
				end
			end
			ST_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_done = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		cmd.out_load = cmd.do_pair;
	end
endmodule

### hdl/rmm_dpath.sv
module rmm_dpath
	import rmm_pkg::*;
#(
	parameter int NODES = 16,
	parameter int PIDS = 16,
	parameter int MAX_COLLECT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [2:0]  req_type,
	input  logic [3:0]  node,
	input  logic [3:0]  pid,
	input  logic [3:0]  partner_node,
	input  logic [3:0]  partner_pid,
	input  logic [4:0]  max_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        matched,
	output logic        valid_res,
	output logic [3:0]  ready_pid,
	output logic [15:0] sent_total,
	output logic [15:0] received_total,
	output logic        busy_res,
	output logic        overflow,
	output logic        last
);
	localparam int EPS = NODES * PIDS;
	localparam int AW = (EPS > 1) ? $clog2(EPS) : 1;
	localparam int PW = (PIDS > 1) ? $clog2(PIDS) : 1;
	localparam int LIMW = 5;
	localparam int MCOL = (MAX_COLLECT < 16) ? MAX_COLLECT : 16;

	ep_t mem [EPS];
	ep_t rd_q, me_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic wr_en;
	ep_t wr_data;

	logic [2:0] req_q;
	logic [3:0] node_q, pid_q, pnode_q, ppid_q;
	logic [LIMW-1:0] lim_q, n_q;
	logic me_ok_q, peer_ok_q, self_q;
	logic [AW-1:0] me_a, peer_a, in_a;
	logic [PW:0] sp_q;
	logic busy_q;

	assign me_a = AW'(32'(node_q) * PIDS + 32'(pid_q));
	assign peer_a = AW'(32'(pnode_q) * PIDS + 32'(ppid_q));
	assign in_a = AW'(32'(node) * PIDS + 32'(pid));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clr_wr) clr_q <= clr_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req_type;
			node_q <= node;
			pid_q <= pid;
			pnode_q <= partner_node;
			ppid_q <= partner_pid;
			me_ok_q <= (32'(node) < NODES) && (32'(pid) < PIDS);
			peer_ok_q <= (32'(partner_node) < NODES) && (32'(partner_pid) < PIDS);
			self_q <= (node == partner_node) && (pid == partner_pid);
			lim_q <= (max_count > LIMW'(MCOL)) ? LIMW'(MCOL) : max_count;
			n_q <= '0;
			sp_q <= '0;
			busy_q <= 1'b0;
		end
		if (cmd.rd_me) me_q <= rd_q;
		if (cmd.emit) n_q <= n_q + 1'b1;
		if (cmd.scan_chk) begin
			if (rd_q.pend != '0 || (rd_q.reg_v && rd_q.wait_kind != WAIT_IDLE)) busy_q <= 1'b1;
			if (!(sts.scan_hit && sts.is_collect)) sp_q <= sp_q + 1'b1;
		end
	end

	logic [AW-1:0] scan_a;
	assign scan_a = AW'(32'(node_q) * PIDS + 32'(sp_q[PW-1:0]));

	always_comb begin
		rd_addr = me_a;
		if (cmd.load_req) rd_addr = in_a;
		if (cmd.rd_peer) rd_addr = peer_a;
		if (cmd.scan_rd) rd_addr = scan_a;
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (wr_en) mem[wr_addr] <= wr_data;
	end

	logic node_ok, pair_ok;
	assign node_ok = 32'(node_q) < NODES;
	assign pair_ok = me_ok_q && peer_ok_q;

	always_comb begin
		sts = '0;
		sts.clr_done = (32'(clr_q) == EPS - 1);
		sts.is_pair = pair_ok && (req_q == REQ_SEND || req_q == REQ_RECEIVE);
		sts.is_collect = req_q == REQ_COLLECT;
		sts.is_scan = node_ok && (req_q == REQ_COLLECT || req_q == REQ_QUERY)
			&& !(req_q == REQ_COLLECT && lim_q == '0);
		sts.scan_hit = rd_q.pend != '0;
		sts.scan_end = 32'(sp_q) == PIDS - 1;
		sts.emit_end = (n_q + 1'b1 == lim_q)
			|| (rd_q.pend == 4'd1 && 32'(sp_q) == PIDS - 1);
		sts.out_busy = out_valid && !out_ready;
	end

	// pair evaluation on me_q and peer in rd_q
	logic [1:0] want;
	logic hit, ov;
	ep_t me_n, pe_n;
	logic [7:0] me_tag;
	assign me_tag = {node_q, pid_q};
	assign want = (req_q == REQ_SEND) ? WAIT_RECV : WAIT_SEND;

	always_comb begin
		ep_t pr;
		pr = self_q ? me_q : rd_q;
		hit = pr.reg_v && pr.wait_kind == want && pr.partner == me_tag;
		ov = 1'b0;
		me_n = me_q;
		pe_n = pr;
		if (hit) begin
			pe_n.wait_kind = WAIT_IDLE;
			pe_n.partner = '0;
			if (self_q) me_n = pe_n;
			if (req_q == REQ_SEND) begin
				if (me_n.sent == CNT_MAX) ov = 1'b1; else me_n.sent = me_n.sent + 1'b1;
				if (self_q) pe_n = me_n;
				if (pe_n.recv == CNT_MAX) ov = 1'b1; else pe_n.recv = pe_n.recv + 1'b1;
			end else begin
				if (me_n.recv == CNT_MAX) ov = 1'b1; else me_n.recv = me_n.recv + 1'b1;
				if (self_q) pe_n = me_n;
				if (pe_n.sent == CNT_MAX) ov = 1'b1; else pe_n.sent = pe_n.sent + 1'b1;
			end
			if (self_q) me_n = pe_n;
			if (me_n.pend == PEND_MAX) ov = 1'b1; else me_n.pend = me_n.pend + 1'b1;
			if (self_q) pe_n = me_n;
			if (pe_n.pend == PEND_MAX) ov = 1'b1; else pe_n.pend = pe_n.pend + 1'b1;
			if (self_q) me_n = pe_n;
		end else begin
			me_n.wait_kind = req_q[1:0];
			me_n.partner = {pnode_q, ppid_q};
		end
	end

	// second write for the peer, in the cycle after the requester write
	logic pw_q;
	ep_t pw_d_q;
	logic [AW-1:0] pw_a_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pw_q <= 1'b0;
		else pw_q <= cmd.do_pair && sts.is_pair && hit && !self_q;
	end
	always_ff @(posedge clk) begin
		pw_d_q <= pe_n;
		pw_a_q <= peer_a;
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = me_a;
		wr_data = me_n;
		if (cmd.clr_wr) begin
			wr_en = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (pw_q) begin
			wr_en = 1'b1;
			wr_addr = pw_a_q;
			wr_data = pw_d_q;
		end else if (cmd.do_pair) begin
			if (sts.is_pair) wr_en = 1'b1;
			else if (req_q == REQ_REGISTER && me_ok_q) begin
				wr_en = 1'b1;
				wr_data = me_q;
				wr_data.reg_v = 1'b1;
				wr_data.wait_kind = WAIT_IDLE;
				wr_data.partner = '0;
				wr_data.sent = '0;
				wr_data.recv = '0;
			end
		end else if (cmd.emit) begin
			wr_en = 1'b1;
			wr_addr = scan_a;
			wr_data = rd_q;
			wr_data.pend = rd_q.pend - 1'b1;
		end
	end

	// completion held back until it is known whether another one follows
	logic hold_v_q;
	logic [3:0] hold_pid_q;
	logic [15:0] hold_sent_q, hold_recv_q;
	always_ff @(posedge clk) begin
		if (cmd.load_req) hold_v_q <= 1'b0;
		else if (cmd.emit) begin
			hold_v_q <= 1'b1;
			hold_pid_q <= 4'(sp_q);
			hold_sent_q <= rd_q.sent;
			hold_recv_q <= rd_q.recv;
		end
	end

	// output register
	logic res_m, res_o, emit_out, fin_out;
	assign emit_out = cmd.emit && hold_v_q;
	assign fin_out = cmd.out_done && sts.is_scan;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.out_load || emit_out || fin_out) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end
	assign res_m = sts.is_pair && hit;
	assign res_o = sts.is_pair && ov;
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			matched <= res_m;
			overflow <= res_o;
			valid_res <= 1'b0;
			ready_pid <= '0;
			sent_total <= '0;
			received_total <= '0;
			busy_res <= 1'b0;
			last <= 1'b1;
		end else if (emit_out) begin
			matched <= 1'b0;
			overflow <= 1'b0;
			valid_res <= 1'b1;
			ready_pid <= hold_pid_q;
			sent_total <= hold_sent_q;
			received_total <= hold_recv_q;
			busy_res <= 1'b0;
			last <= 1'b0;
		end else if (fin_out) begin
			matched <= 1'b0;
			overflow <= 1'b0;
			valid_res <= hold_v_q;
			ready_pid <= hold_v_q ? hold_pid_q : '0;
			sent_total <= hold_v_q ? hold_sent_q : '0;
			received_total <= hold_v_q ? hold_recv_q : '0;
			busy_res <= (req_q == REQ_QUERY) && busy_q;
			last <= 1'b1;
		end
	end
endmodule

### hdl/rmm_checker.sv
`include "rendezvous_message_matcher_unit_assert.svh"
module rmm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic matched,
	input logic valid_res,
	input logic busy_res,
	input logic last
);
	`RMM_ASSERT_IMP(a_match_last, out_valid && matched, last && !valid_res)
	`RMM_ASSERT_IMP(a_busy_excl, out_valid && busy_res, !valid_res && !matched)
	`RMM_ASSERT_NXT(a_accept_blocks, in_valid && in_ready, !in_ready)
	`RMM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
endmodule

bind rendezvous_message_matcher_unit rmm_checker u_rmm_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
	.matched, .valid_res, .busy_res, .last
);
